### hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Spectral tensor contraction package
// Shared types, field positions, codes and the saturation and rounding helpers.
// ----------------------------------------------------------------------------
package stc_pkg;

   // request item kinds, carried on req_tuser
   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_CONTRACT = 1'b1;

   // row code that addresses no tensor row
   localparam logic [1:0] ROW_SKIP = 2'd3;

   // channel widths
   localparam int unsigned REQ_W = 216;
   localparam int unsigned RSP_W = 192;
   localparam int unsigned ROW_W = 192;

   // request tdata layout
   localparam int unsigned TD_CELL_LSB = 0;
   localparam int unsigned TD_ROW_LSB  = 12;
   localparam int unsigned TD_TB_LSB   = 14;
   localparam int unsigned TD_SB_LSB   = 16;
   localparam int unsigned TD_VAL_LSB  = 18;

   // result queue
   localparam int unsigned OQ_DEPTH = 8;
   localparam int unsigned OQ_AW    = 3;
   localparam int unsigned OQ_CW    = 4;

   localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic vld;
      logic ok;
      logic last;
   } ctl_type;

   // clamp a 65-bit sum back into the signed 64-bit range
   function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
      logic signed [63:0] r;
      if (x[64] != x[63]) begin
         r = x[64] ? ACC_MIN : ACC_MAX;
      end else begin
         r = x[63:0];
      end
      return r;
   endfunction

   // Q32.32 to Q16.16, round half up, saturate
   function automatic logic [31:0] round_q16(input logic signed [63:0] a);
      logic signed [48:0] q;
      logic [31:0]        r;
      q = $signed({a[63], a[63:16]}) + $signed({48'd0, a[15]});
      if (q > 49'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (q < -49'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/spectral_tensor_contraction.sv
// ----------------------------------------------------------------------------
// Spectral tensor contraction
// Per-cell complex 3x3 tensor table with streaming tensor-vector contraction.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                               tuser  tlast
//  req_     in   cell_req,row,tgt,src,x/y/z re,im    func   last_source
//  rsp_     out  field x/y/z re,im                   -      -
//
//  One item per cycle, write or contract, while req_tready is high; it drops
//  only while eight results are in flight or queued. A result passes the
//  read, product, term, fold and accumulate registers into the queue; the
//  accumulate step (one add and one clamp against precomputed bounds) is the
//  only loop and sets the rate. Reset clears the sums, the pipeline and the
//  result queue; the tensor table holds garbage until written.
// ----------------------------------------------------------------------------
module spectral_tensor_contraction #(
   parameter int unsigned CELLS = 4096,
   parameter int unsigned BASIS = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // cell_req[11:0], row[13:12], tgt_basis[15:14], src_basis[17:16],
   // value_x_re, value_x_im, value_y_re, value_y_im, value_z_re, value_z_im
   // (32 each from bit 18), zero pad [215:210]
   input  logic [stc_pkg::REQ_W-1:0] req_tdata,
   // func
   input  logic                      req_tuser,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // field_x_re, field_x_im, field_y_re, field_y_im, field_z_re, field_z_im
   output logic [stc_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int unsigned BB    = BASIS * BASIS;
   localparam int unsigned DEPTH = CELLS * BB;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ---------------- request decode ----------------
   logic                      req_acc;
   logic                      rsp_acc;
   logic [11:0]               cell_idx;
   logic [1:0]                row;
   logic [1:0]                tb;
   logic [1:0]                sb;
   logic [31:0]               tix;
   logic                      ok;
   logic                      wr_en;
   logic [AW-1:0]             tab_addr;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   assign cell_idx = req_tdata[stc_pkg::TD_CELL_LSB +: 12];
   assign row      = req_tdata[stc_pkg::TD_ROW_LSB +: 2];
   assign tb       = req_tdata[stc_pkg::TD_TB_LSB +: 2];
   assign sb       = req_tdata[stc_pkg::TD_SB_LSB +: 2];

   assign tix = 32'(cell_idx) * 32'(BB) + 32'(tb) * 32'(BASIS) + 32'(sb);
   assign ok  = (32'(cell_idx) < 32'(CELLS)) && (32'(tb) < 32'(BASIS))
                && (32'(sb) < 32'(BASIS));
   assign tab_addr = tix[AW-1:0];
   assign wr_en = (req_tuser == stc_pkg::FUNC_WRITE) && ok && (row != stc_pkg::ROW_SKIP);

   // ---------------- tensor table, one lane per row ----------------
   logic [2:0][stc_pkg::ROW_W-1:0] tab_mem [DEPTH];
   logic [2:0][stc_pkg::ROW_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         for (int r = 0; r < 3; r++) begin
            if (wr_en && (row == 2'(r))) begin
               tab_mem[tab_addr][r] <= req_tdata[stc_pkg::TD_VAL_LSB +: stc_pkg::ROW_W];
            end
            rd_ff[r] <= tab_mem[tab_addr][r];
         end
      end
   end

   // ---------------- stage 1: moments and control ----------------
   stc_pkg::ctl_type c1_ff, c1_in;
   stc_pkg::ctl_type c2_ff, c2_in;
   stc_pkg::ctl_type c3_ff, c3_in;
   stc_pkg::ctl_type c4_ff, c4_in;
   stc_pkg::ctl_type c5_ff, c5_in;
   logic [5:0][31:0] mom_ff, mom_in;

   always_comb begin
      c1_in.vld  = req_acc && (req_tuser == stc_pkg::FUNC_CONTRACT);
      c1_in.ok   = ok;
      c1_in.last = req_tlast;
      mom_in     = req_tdata[stc_pkg::TD_VAL_LSB +: stc_pkg::ROW_W];
   end

   // ---------------- stage 2: 36 products ----------------
   logic signed [63:0] prod_ff [3][3][4];
   logic signed [63:0] prod_in [3][3][4];

   always_comb begin
      logic signed [31:0] kr, ki, mr, mi;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            kr = $signed(rd_ff[r][64*c +: 32]);
            ki = $signed(rd_ff[r][64*c+32 +: 32]);
            mr = $signed(mom_ff[2*c]);
            mi = $signed(mom_ff[2*c+1]);
            prod_in[r][c][0] = 64'(kr) * 64'(mr);
            prod_in[r][c][1] = 64'(ki) * 64'(mi);
            prod_in[r][c][2] = 64'(kr) * 64'(mi);
            prod_in[r][c][3] = 64'(ki) * 64'(mr);
         end
      end
      c2_in = c1_ff;
   end

   // ---------------- stage 3: complex terms per sum and column ----------------
   logic signed [63:0] term_ff [6][3];
   logic signed [63:0] term_in [6][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (c2_ff.ok) begin
               term_in[2*r][c]   = prod_ff[r][c][0] - prod_ff[r][c][1];
               term_in[2*r+1][c] = prod_ff[r][c][2] + prod_ff[r][c][3];
            end else begin
               term_in[2*r][c]   = '0;
               term_in[2*r+1][c] = '0;
            end
         end
      end
      c3_in = c2_ff;
   end

   // ---------------- stages 4 and 5: fold the three saturating adds ----------
   // Three clamped adds compose into one: clamp(acc + d, lo, hi).
   logic signed [64:0] d1_ff [6];
   logic signed [64:0] d1_in [6];
   logic signed [63:0] l1_ff [6];
   logic signed [63:0] l1_in [6];
   logic signed [63:0] h1_ff [6];
   logic signed [63:0] h1_in [6];
   logic signed [63:0] t2_ff [6];
   logic signed [63:0] t2_in [6];
   logic signed [65:0] d2_ff [6];
   logic signed [65:0] d2_in [6];
   logic signed [63:0] l2_ff [6];
   logic signed [63:0] l2_in [6];
   logic signed [63:0] h2_ff [6];
   logic signed [63:0] h2_in [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         d1_in[k] = 65'(term_ff[k][0]) + 65'(term_ff[k][1]);
         l1_in[k] = term_ff[k][1][63] ? stc_pkg::ACC_MIN : stc_pkg::ACC_MIN + term_ff[k][1];
         h1_in[k] = term_ff[k][1][63] ? stc_pkg::ACC_MAX + term_ff[k][1] : stc_pkg::ACC_MAX;
         t2_in[k] = term_ff[k][2];
      end
      c4_in = c3_ff;
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         d2_in[k] = 66'(d1_ff[k]) + 66'(t2_ff[k]);
         l2_in[k] = stc_pkg::sat64(65'(l1_ff[k]) + 65'(t2_ff[k]));
         h2_in[k] = stc_pkg::sat64(65'(h1_ff[k]) + 65'(t2_ff[k]));
      end
      c5_in = c4_ff;
   end

   // ---------------- accumulate ----------------
   logic signed [63:0] acc_ff [6];
   logic signed [63:0] acc_in [6];
   logic signed [63:0] fin_ff [6];
   logic signed [63:0] fin_in [6];
   logic               fin_v_ff, fin_v_in;

   always_comb begin
      logic signed [66:0] x;
      for (int k = 0; k < 6; k++) begin
         x = 67'(acc_ff[k]) + 67'(d2_ff[k]);
         if (x < 67'(l2_ff[k])) begin
            fin_in[k] = l2_ff[k];
         end else if (x > 67'(h2_ff[k])) begin
            fin_in[k] = h2_ff[k];
         end else begin
            fin_in[k] = x[63:0];
         end
         if (c5_ff.vld) begin
            acc_in[k] = c5_ff.last ? '0 : fin_in[k];
         end else begin
            acc_in[k] = acc_ff[k];
         end
      end
      fin_v_in = c5_ff.vld && c5_ff.last;
   end

   // ---------------- round and queue results ----------------
   logic [stc_pkg::RSP_W-1:0]    rnd_data;
   logic [stc_pkg::RSP_W-1:0]    oq_mem [stc_pkg::OQ_DEPTH];
   logic [stc_pkg::OQ_AW-1:0]    oq_wr_ff, oq_wr_in;
   logic [stc_pkg::OQ_AW-1:0]    oq_rd_ff, oq_rd_in;
   logic [stc_pkg::OQ_CW-1:0]    oq_cnt_ff, oq_cnt_in;
   logic [stc_pkg::OQ_CW-1:0]    pend_ff, pend_in;
   logic                         pend_add;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         rnd_data[32*k +: 32] = stc_pkg::round_q16(fin_ff[k]);
      end
   end

   assign pend_add = req_acc && (req_tuser == stc_pkg::FUNC_CONTRACT) && req_tlast;

   always_comb begin
      oq_wr_in  = oq_wr_ff + stc_pkg::OQ_AW'(fin_v_ff);
      oq_rd_in  = oq_rd_ff + stc_pkg::OQ_AW'(rsp_acc);
      oq_cnt_in = oq_cnt_ff + stc_pkg::OQ_CW'(fin_v_ff) - stc_pkg::OQ_CW'(rsp_acc);
      pend_in   = pend_ff + stc_pkg::OQ_CW'(pend_add) - stc_pkg::OQ_CW'(rsp_acc);
   end

   // reserve a queue slot for every last-source item in flight
   assign req_tready = pend_ff < stc_pkg::OQ_CW'(stc_pkg::OQ_DEPTH);
   assign rsp_tvalid = oq_cnt_ff != '0;
   assign rsp_tdata  = oq_mem[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (fin_v_ff) begin
         oq_mem[oq_wr_ff] <= rnd_data;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      mom_ff <= mom_in;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
               prod_ff[r][c][j] <= prod_in[r][c][j];
            end
         end
      end
      for (int k = 0; k < 6; k++) begin
         for (int c = 0; c < 3; c++) begin
            term_ff[k][c] <= term_in[k][c];
         end
         d1_ff[k] <= d1_in[k];
         l1_ff[k] <= l1_in[k];
         h1_ff[k] <= h1_in[k];
         t2_ff[k] <= t2_in[k];
         d2_ff[k] <= d2_in[k];
         l2_ff[k] <= l2_in[k];
         h2_ff[k] <= h2_in[k];
         fin_ff[k] <= fin_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff     <= '0;
         c2_ff     <= '0;
         c3_ff     <= '0;
         c4_ff     <= '0;
         c5_ff     <= '0;
         fin_v_ff  <= 1'b0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
         pend_ff   <= '0;
         for (int k = 0; k < 6; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         c1_ff     <= c1_in;
         c2_ff     <= c2_in;
         c3_ff     <= c3_in;
         c4_ff     <= c4_in;
         c5_ff     <= c5_in;
         fin_v_ff  <= fin_v_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
         pend_ff   <= pend_in;
         for (int k = 0; k < 6; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

`ifndef SYNTHESIS
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= stc_pkg::OQ_CW'(stc_pkg::OQ_DEPTH))
      else $error("result reservations exceed queue depth");

   a_oq_room: assert property (@(posedge clock) disable iff (reset)
      fin_v_ff |-> (oq_cnt_ff < stc_pkg::OQ_CW'(stc_pkg::OQ_DEPTH)) || rsp_acc)
      else $error("result written into a full queue");

   a_oq_reserved: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= pend_ff)
      else $error("queued results without reservation");
`endif

endmodule

### dv/spectral_tensor_contraction_test.sv
// ----------------------------------------------------------------------------
// Spectral tensor contraction testbench
// Loads complex 3x3 tensors into the table, streams moment items against them
// and compares every field result with a cycle-free model of the table and the
// six Q32.32 sums. Directed corners come first, then random traffic, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module spectral_tensor_contraction_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CELLS = 4096;
   localparam int unsigned BASIS = 1;

   // six 32-bit words: x re, x im, y re, y im, z re, z im (x re lowest)
   typedef logic [5:0][31:0] cplx3_type;

   typedef struct packed {
      logic        func;
      logic [11:0] cell_idx;
      logic [1:0]  row;
      logic [1:0]  tbasis;
      logic [1:0]  sbasis;
      cplx3_type   val;
      logic        last;
   } stc_item_type;

   typedef struct packed {
      logic [11:0] cell_idx;
      logic [1:0]  tbasis;
      logic [1:0]  sbasis;
   } tensor_sel_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // cell_req, row, tgt_basis, src_basis, x/y/z re,im, zero pad
   logic [stc_pkg::REQ_W-1:0] req_tdata = '0;
   // func
   logic                      req_tuser = 1'b0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // field x/y/z re,im
   logic [stc_pkg::RSP_W-1:0] rsp_tdata;

   spectral_tensor_contraction #(
      .CELLS(CELLS),
      .BASIS(BASIS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [63:0]     tensor_mem [int];
   logic [2:0]      rows_loaded [int];
   tensor_sel_type  ready_sel [$];
   longint          field_sum [6] = '{default: 0};
   cplx3_type       expected_fields [$];

   int unsigned  items_sent = 0;
   int unsigned  mismatches = 0;
   bit           tx_burst = 1'b0;
   int unsigned  rx_hold = 0;

   string field_label [6] = '{"x_re", "x_im", "y_re", "y_im", "z_re", "z_im"};

   function automatic longint sat_add64(input longint acc, input longint term);
      longint s;
      s = acc + term;
      if (acc[63] == term[63] && s[63] != acc[63]) begin
         s = acc[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   // update the table and the sums for one accepted item
   function automatic void apply_item(input stc_item_type it);
      int             key;
      bit             in_range;
      logic [63:0]    entry;
      longint         kr, ki, mr, mi, q;
      cplx3_type      fields;
      tensor_sel_type sel;
      in_range = (it.cell_idx < CELLS) && (it.tbasis < BASIS) && (it.sbasis < BASIS);
      key = (int'(it.cell_idx) * BASIS + int'(it.tbasis)) * BASIS + int'(it.sbasis);
      if (it.func == stc_pkg::FUNC_WRITE) begin
         if (in_range && it.row != stc_pkg::ROW_SKIP) begin
            for (int c = 0; c < 3; c++) begin
               tensor_mem[key * 9 + int'(it.row) * 3 + c] = {it.val[2*c+1], it.val[2*c]};
            end
            if (!rows_loaded.exists(key)) begin
               rows_loaded[key] = 3'b000;
            end
            if (rows_loaded[key] != 3'b111 &&
                (rows_loaded[key] | (3'b001 << it.row)) == 3'b111) begin
               sel.cell_idx = it.cell_idx;
               sel.tbasis   = it.tbasis;
               sel.sbasis   = it.sbasis;
               ready_sel.push_back(sel);
            end
            rows_loaded[key] = rows_loaded[key] | (3'b001 << it.row);
         end
         return;
      end
      if (in_range) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               entry = tensor_mem[key * 9 + r * 3 + c];
               kr = $signed(entry[31:0]);
               ki = $signed(entry[63:32]);
               mr = $signed(it.val[2*c]);
               mi = $signed(it.val[2*c+1]);
               field_sum[2*r]   = sat_add64(field_sum[2*r], kr * mr - ki * mi);
               field_sum[2*r+1] = sat_add64(field_sum[2*r+1], kr * mi + ki * mr);
            end
         end
      end
      if (it.last) begin
         for (int i = 0; i < 6; i++) begin
            // round half up: floor, then add the half-LSB bit
            q = field_sum[i] >>> 16;
            if (field_sum[i][15]) begin
               q = q + 1;
            end
            if (q > 64'sd2147483647) begin
               fields[i] = 32'h7FFF_FFFF;
            end else if (q < -64'sd2147483648) begin
               fields[i] = 32'h8000_0000;
            end else begin
               fields[i] = q[31:0];
            end
            field_sum[i] = 0;
         end
         expected_fields.push_back(fields);
      end
   endfunction

   function automatic stc_item_type make_item(input logic func, input logic [11:0] cell_idx,
                                              input logic [1:0] row, input logic [1:0] tbasis,
                                              input logic [1:0] sbasis, input cplx3_type val,
                                              input logic last);
      stc_item_type it;
      it.func     = func;
      it.cell_idx = cell_idx;
      it.row      = row;
      it.tbasis   = tbasis;
      it.sbasis   = sbasis;
      it.val      = val;
      it.last     = last;
      return it;
   endfunction

   function automatic logic [31:0] rand_word();
      int unsigned pick;
      logic [31:0] w;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // moderate magnitude, keeps the sums clear of saturation
         w = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      end else if (pick < 80) begin
         w = $urandom;
      end else begin
         case ($urandom_range(0, 7))
            0: w = 32'h0000_0000;
            1: w = 32'h0000_0001;
            2: w = 32'hFFFF_FFFF;
            3: w = 32'h7FFF_FFFF;
            4: w = 32'h8000_0000;
            5: w = 32'h0000_8000;
            6: w = 32'h0001_0000;
            default: w = 32'hFFFF_8000;
         endcase
      end
      return w;
   endfunction

   function automatic cplx3_type rand_vals();
      cplx3_type v;
      for (int i = 0; i < 6; i++) begin
         v[i] = rand_word();
      end
      return v;
   endfunction

   // a selector whose basis pair lies outside the table
   function automatic tensor_sel_type bad_sel();
      tensor_sel_type sel;
      sel.cell_idx = 12'($urandom_range(0, 4095));
      sel.tbasis   = 2'($urandom_range(0, 3));
      if (sel.tbasis >= BASIS) begin
         sel.sbasis = 2'($urandom_range(0, 3));
      end else begin
         sel.sbasis = 2'($urandom_range(BASIS, 3));
      end
      return sel;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (tx_burst || pick < 60) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   task automatic send_item(input stc_item_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tlast  <= it.last;
      req_tdata  <= {6'd0, it.val, it.sbasis, it.tbasis, it.row, it.cell_idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_item(it);
      items_sent++;
   endtask

   // hold the request side until every expected result is out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
   endtask

   task automatic test_tensor_writes();
      // cell 0: every entry at the most negative value; one write carries tlast
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd0, 2'd0, 2'd0, 2'd0,
                          {6{32'h8000_0000}}, 1'b0));
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd0, 2'd1, 2'd0, 2'd0,
                          {6{32'h8000_0000}}, 1'b1));
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd0, 2'd2, 2'd0, 2'd0,
                          {6{32'h8000_0000}}, 1'b0));
      // top cell: sparse entries aimed at the half-LSB rounding points
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd4095, 2'd0, 2'd0, 2'd0,
                          {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_8000}, 1'b0));
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd4095, 2'd1, 2'd0, 2'd0,
                          {32'h0, 32'h0, 32'hFFFF_8000, 32'h0001_0000, 32'h0, 32'h0}, 1'b0));
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd4095, 2'd2, 2'd0, 2'd0,
                          {32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1, 32'h1}, 1'b0));
      // both must leave the table alone
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd0, stc_pkg::ROW_SKIP, 2'd0, 2'd0,
                          {6{32'h1234_5678}}, 1'b0));
      send_item(make_item(stc_pkg::FUNC_WRITE, 12'd0, 2'd1, 2'd3, 2'd2,
                          {6{32'h7FFF_FFFF}}, 1'b0));
      drain_results();
   endtask

   task automatic test_contract_corners();
      // positive then negative 64-bit saturation
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd0, 2'd0, 2'd0, 2'd0,
                          {3{32'h7FFF_FFFF, 32'h8000_0000}}, 1'b1));
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd0, 2'd3, 2'd0, 2'd0,
                          {3{32'h8000_0000, 32'h7FFF_FFFF}}, 1'b1));
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd0, 2'd0, 2'd0, 2'd0,
                          {6{32'h7FFF_FFFF}}, 1'b1));
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd0, 2'd0, 2'd0, 2'd0,
                          {6{32'h0}}, 1'b1));
      // rounding at exactly one half, both signs
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd4095, 2'd0, 2'd0, 2'd0,
                          {32'h0, 32'h0000_8000, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1},
                          1'b1));
      // accumulate across items; the out-of-range one adds nothing
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd4095, 2'd0, 2'd0, 2'd0,
                          {32'h0, 32'h1, 32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0));
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd0, 2'd0, 2'd1, 2'd0,
                          {6{32'h7FFF_FFFF}}, 1'b0));
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd4095, 2'd0, 2'd0, 2'd0,
                          {32'h0, 32'h1, 32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1));
      // out of range alone still emits and clears
      send_item(make_item(stc_pkg::FUNC_CONTRACT, 12'd2730, 2'd0, 2'd2, 2'd3,
                          {6{32'hFFFF_FFFF}}, 1'b1));
      drain_results();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned    start, pick, n, first;
      bit             drained;
      tensor_sel_type sel;
      start   = items_sent;
      drained = 1'b0;
      while (items_sent - start < n_items) begin
         // stretches with no request gaps
         tx_burst = ((items_sent / 64) % 5 == 0);
         if (!drained && items_sent - start >= n_items / 2) begin
            drain_results();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (ready_sel.size() == 0 || pick < 15) begin
            // load a full tensor, rows in rotated order
            sel.cell_idx = 12'($urandom_range(0, CELLS - 1));
            sel.tbasis   = 2'($urandom_range(0, BASIS - 1));
            sel.sbasis   = 2'($urandom_range(0, BASIS - 1));
            first = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) begin
               send_item(make_item(stc_pkg::FUNC_WRITE, sel.cell_idx, 2'((first + k) % 3),
                                   sel.tbasis, sel.sbasis, rand_vals(),
                                   1'($urandom_range(0, 1))));
            end
         end else if (pick < 75) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               if (BASIS < 4 && $urandom_range(0, 9) == 0) begin
                  sel = bad_sel();
               end else begin
                  sel = ready_sel[$urandom_range(0, ready_sel.size() - 1)];
               end
               send_item(make_item(stc_pkg::FUNC_CONTRACT, sel.cell_idx,
                                   2'($urandom_range(0, 3)), sel.tbasis, sel.sbasis,
                                   rand_vals(), 1'(k == n - 1)));
            end
         end else if (pick < 85) begin
            sel = ready_sel[$urandom_range(0, ready_sel.size() - 1)];
            send_item(make_item(stc_pkg::FUNC_WRITE, sel.cell_idx, 2'($urandom_range(0, 2)),
                                sel.tbasis, sel.sbasis, rand_vals(),
                                1'($urandom_range(0, 1))));
         end else begin
            sel = (BASIS < 4) ? bad_sel() : ready_sel[0];
            case ($urandom_range(0, 2))
               0: send_item(make_item(stc_pkg::FUNC_WRITE, 12'($urandom_range(0, 4095)),
                                      stc_pkg::ROW_SKIP, 2'($urandom_range(0, BASIS - 1)),
                                      2'($urandom_range(0, BASIS - 1)), rand_vals(),
                                      1'($urandom_range(0, 1))));
               1: send_item(make_item(stc_pkg::FUNC_WRITE, sel.cell_idx,
                                      2'($urandom_range(0, 3)), sel.tbasis, sel.sbasis,
                                      rand_vals(), 1'($urandom_range(0, 1))));
               default: send_item(make_item(stc_pkg::FUNC_CONTRACT, sel.cell_idx,
                                            2'($urandom_range(0, 3)), sel.tbasis,
                                            sel.sbasis, rand_vals(),
                                            1'($urandom_range(0, 1))));
            endcase
         end
      end
      tx_burst = 1'b0;
   endtask

   // result-side backpressure: short and long stalls, with stall-free stretches
   always @(posedge clock) begin
      int unsigned pick;
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rsp_tready <= 1'b1;
            rx_hold    <= $urandom_range(0, 7);
         end else if (pick < 85) begin
            rsp_tready <= 1'b0;
            rx_hold    <= $urandom_range(0, 2);
         end else if (pick < 95) begin
            rsp_tready <= 1'b0;
            rx_hold    <= $urandom_range(7, 39);
         end else begin
            rsp_tready <= 1'b1;
            rx_hold    <= $urandom_range(99, 299);
         end
      end
   end

   always @(posedge clock) begin
      cplx3_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fields.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected result: data %h", rsp_tdata);
            end
            mismatches++;
         end else begin
            want = expected_fields.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (rsp_tdata[32*i +: 32] !== want[i]) begin
                  if (mismatches < 10) begin
                     $display("field %s: expected %h, got %h", field_label[i], want[i],
                              rsp_tdata[32*i +: 32]);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tensor_writes();
      test_contract_corners();
      test_random_traffic(1030);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_fields.size() == 0) begin
         $display("spectral_tensor_contraction: match");
      end else begin
         $display("spectral_tensor_contraction: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("spectral_tensor_contraction: mismatch");
      $finish;
   end

endmodule
